// ===== sv/cars_pkg.sv =====
// Shared types, constants and opcode patterns for the code address reference scanner.
package cars_pkg;

    // Widths of the datapath.
    localparam int WORD_W       = 32;
    localparam int OFF_W        = 32;
    localparam int VALUE_W      = 64;
    localparam int NUM_REGS     = 32;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);

    // Offset bits kept from the incoming offset.
    localparam int OFFSET_WIDTH = 32;
    localparam logic [OFF_W-1:0] OFFSET_MASK = (OFFSET_WIDTH >= OFF_W) ? {OFF_W{1'b1}} :
        OFF_W'((64'd1 << OFFSET_WIDTH) - 64'd1);

    // Decoupling queue between decode and execute.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Opcode masks and match values.
    localparam logic [WORD_W-1:0] ADRP_MASK  = 32'h9f00_0000;
    localparam logic [WORD_W-1:0] ADRP_MATCH = 32'h9000_0000;
    localparam logic [WORD_W-1:0] ADDI_MASK  = 32'hff00_0000;
    localparam logic [WORD_W-1:0] ADDI_MATCH = 32'h9100_0000;
    localparam logic [WORD_W-1:0] LDRU_MASK  = 32'hf9c0_0000;
    localparam logic [WORD_W-1:0] LDRU_MATCH = 32'hf940_0000;
    localparam logic [WORD_W-1:0] ADR_MASK   = 32'h9f00_0000;
    localparam logic [WORD_W-1:0] ADR_MATCH  = 32'h1000_0000;
    localparam logic [WORD_W-1:0] LDRL_MASK  = 32'hff00_0000;
    localparam logic [WORD_W-1:0] LDRL_MATCH = 32'h5800_0000;
    localparam logic [WORD_W-1:0] BL_MASK    = 32'hfc00_0000;
    localparam logic [WORD_W-1:0] BL_MATCH   = 32'h9400_0000;

    // Register 31 is the zero or stack register.
    localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'h1f;

    // Shift codes of ADD immediate.
    localparam logic [1:0] ADD_SH_NONE = 2'd0;
    localparam logic [1:0] ADD_SH_12   = 2'd1;

    // What the execute stage does with a decoded word.
    typedef enum logic [2:0] {
        CLS_OTHER,  // no write, tracked check on rd
        CLS_SET,    // rd gets operand, checked
        CLS_CLEAR,  // rd gets zero, no check
        CLS_ACCUM,  // rd gets rn value plus operand, checked
        CLS_BL,     // branch target compare, then tracked check on rd
        CLS_QUIET   // no write, no check
    } op_class_t;

    // Kind of reference found.
    typedef enum logic [1:0] {
        HIT_NONE    = 2'd0,
        HIT_BL      = 2'd1,
        HIT_TRACKED = 2'd2
    } hit_kind_t;

    // One decoded word as it travels from decode to execute.
    typedef struct packed {
        op_class_t              cls;
        logic [REG_IDX_W-1:0]   rd;
        logic [REG_IDX_W-1:0]   rn;
        logic [VALUE_W-1:0]     operand;
        logic [OFF_W-1:0]       offset;
        logic                   scan;
    } item_t;

endpackage

// ===== sv/cars_front.sv =====
// Decode stage: accepts instruction words and classifies them into execute requests.
module cars_front (
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // instr_word [31:0], instr_offset [63:32]
    input  logic                   s_tuser,   // scan_start
    input  logic                   queue_full,
    output logic                   push,
    output cars_pkg::item_t        push_item
);

    logic [cars_pkg::WORD_W-1:0]  word;
    logic [cars_pkg::OFF_W-1:0]   off;
    logic [20:0]                  imm21;
    logic [cars_pkg::VALUE_W-1:0] off64;
    logic [cars_pkg::VALUE_W-1:0] adrp_val;
    logic [cars_pkg::VALUE_W-1:0] adr_val;
    logic [cars_pkg::VALUE_W-1:0] lit_val;
    logic [cars_pkg::VALUE_W-1:0] add_imm;
    logic [cars_pkg::VALUE_W-1:0] ldr_imm;
    logic [cars_pkg::OFF_W-1:0]   bl_imm;
    logic [cars_pkg::OFF_W-1:0]   bl_dest;

    // The queue takes a request whenever it has room.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Field extraction and the state-independent values of each form.
    always_comb begin
        word     = s_tdata[31:0];
        off      = s_tdata[63:32] & cars_pkg::OFFSET_MASK & ~32'd3;
        imm21    = {word[23:5], word[30:29]};
        off64    = {32'd0, off};
        adrp_val = {{31{imm21[20]}}, imm21, 12'd0} + {32'd0, off[31:12], 12'd0};
        adr_val  = {{43{imm21[20]}}, imm21} + off64;
        lit_val  = {43'd0, word[23:5], 2'd0} + off64;
        add_imm  = (word[23:22] == cars_pkg::ADD_SH_12) ? {40'd0, word[21:10], 12'd0}
                                                        : {52'd0, word[21:10]};
        ldr_imm  = {49'd0, word[21:10], 3'd0};
        bl_imm   = {{4{word[25]}}, word[25:0], 2'd0};
        bl_dest  = off + bl_imm;
    end

    // Classification, in the priority order of the opcode patterns.
    always_comb begin
        push_item.cls     = cars_pkg::CLS_OTHER;
        push_item.rd      = word[4:0];
        push_item.rn      = word[9:5];
        push_item.operand = '0;
        push_item.offset  = off;
        push_item.scan    = s_tuser;
        if ((word & cars_pkg::ADRP_MASK) == cars_pkg::ADRP_MATCH) begin
            push_item.cls     = cars_pkg::CLS_SET;
            push_item.operand = adrp_val;
        end else if ((word & cars_pkg::ADDI_MASK) == cars_pkg::ADDI_MATCH) begin
            if (word[9:5] == cars_pkg::ZERO_REG) begin
                push_item.cls = cars_pkg::CLS_CLEAR;
            end else if (word[23:22] > cars_pkg::ADD_SH_12) begin
                // Reserved shift: the word is ignored.
                push_item.cls = cars_pkg::CLS_QUIET;
            end else begin
                push_item.cls     = cars_pkg::CLS_ACCUM;
                push_item.operand = add_imm;
            end
        end else if ((word & cars_pkg::LDRU_MASK) == cars_pkg::LDRU_MATCH) begin
            if (word[21:10] == 12'd0) begin
                push_item.cls = cars_pkg::CLS_QUIET;
            end else begin
                push_item.cls     = cars_pkg::CLS_ACCUM;
                push_item.operand = ldr_imm;
            end
        end else if ((word & cars_pkg::ADR_MASK) == cars_pkg::ADR_MATCH) begin
            push_item.cls     = cars_pkg::CLS_SET;
            push_item.operand = adr_val;
        end else if ((word & cars_pkg::LDRL_MASK) == cars_pkg::LDRL_MATCH) begin
            push_item.cls     = cars_pkg::CLS_SET;
            push_item.operand = lit_val;
        end else if ((word & cars_pkg::BL_MASK) == cars_pkg::BL_MATCH) begin
            push_item.cls     = cars_pkg::CLS_BL;
            push_item.operand = {32'd0, bl_dest};
        end
    end

endmodule

// ===== sv/cars_queue.sv =====
// Short request queue between the decode stage and the execute stage.
module cars_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cars_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output cars_pkg::item_t   head_item
);

    cars_pkg::item_t                  entry_reg [cars_pkg::QUEUE_DEPTH];
    logic [cars_pkg::QUEUE_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cars_pkg::QUEUE_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cars_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == cars_pkg::QUEUE_CNT_W'(cars_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == cars_pkg::QUEUE_IDX_W'(cars_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == cars_pkg::QUEUE_IDX_W'(cars_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/cars_back.sv =====
// Execute stage: tracked register file, value update, hit detection and output register.
module cars_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cars_pkg::VALUE_W-1:0]   target,
    input  logic                           head_valid,
    input  cars_pkg::item_t                head_item,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // hit_offset
    output logic [2:0]                     m_tuser    // hit [0], hit_kind [2:1]
);

    // Tracked register file and its valid bits.
    logic [cars_pkg::VALUE_W-1:0] tracked_mem [cars_pkg::NUM_REGS];
    logic [cars_pkg::NUM_REGS-1:0] tracked_vld_reg, tracked_vld_next;

    // Execute stage registers.
    logic                          b2_valid_reg, b2_valid_next;
    cars_pkg::item_t               b2_item_reg;
    logic [cars_pkg::VALUE_W-1:0]  rn_raw_reg, rd_raw_reg, fwd_data_reg;
    logic                          rn_fwd_reg, rn_fwd_next, rd_fwd_reg, rd_fwd_next;
    logic                          rn_zero_reg, rn_zero_next, rd_zero_reg, rd_zero_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    cars_pkg::hit_kind_t           out_kind_reg, out_kind_next;
    logic [cars_pkg::OFF_W-1:0]    out_offset_reg;

    logic                          out_free;
    logic                          b2_fire;
    logic                          b2_we;
    logic                          b2_wr;
    logic                          b2_check;
    logic [cars_pkg::VALUE_W-1:0]  rn_val, rd_val, base_val, new_val, rd_after;

    // Handshake between queue, execute stage and output register.
    always_comb begin
        out_free = !out_valid_reg || m_tready;
        b2_fire  = b2_valid_reg && out_free;
        pop      = head_valid && (!b2_valid_reg || b2_fire);
    end

    // Operand selection with scan clear and bypass from the previous write.
    always_comb begin
        rn_val   = rn_zero_reg ? '0 : (rn_fwd_reg ? fwd_data_reg : rn_raw_reg);
        rd_val   = rd_zero_reg ? '0 : (rd_fwd_reg ? fwd_data_reg : rd_raw_reg);
        b2_we    = (b2_item_reg.cls == cars_pkg::CLS_SET) ||
                   (b2_item_reg.cls == cars_pkg::CLS_CLEAR) ||
                   (b2_item_reg.cls == cars_pkg::CLS_ACCUM);
        b2_wr    = b2_fire && b2_we;
        b2_check = (b2_item_reg.cls != cars_pkg::CLS_QUIET) &&
                   (b2_item_reg.cls != cars_pkg::CLS_CLEAR);
        base_val = (b2_item_reg.cls == cars_pkg::CLS_ACCUM) ? rn_val : '0;
        new_val  = base_val + b2_item_reg.operand;
        rd_after = b2_we ? new_val : rd_val;
    end

    // Hit classification: the branch target wins over the tracked value.
    always_comb begin
        if (b2_item_reg.cls == cars_pkg::CLS_BL && b2_item_reg.operand == target) begin
            out_kind_next = cars_pkg::HIT_BL;
        end else if (b2_check && b2_item_reg.rd != cars_pkg::ZERO_REG && rd_after == target) begin
            out_kind_next = cars_pkg::HIT_TRACKED;
        end else begin
            out_kind_next = cars_pkg::HIT_NONE;
        end
    end

    // Read-side flags for the request leaving the queue.
    always_comb begin
        rn_fwd_next  = b2_wr && (b2_item_reg.rd == head_item.rn);
        rd_fwd_next  = b2_wr && (b2_item_reg.rd == head_item.rd);
        rn_zero_next = head_item.scan || (!rn_fwd_next && !tracked_vld_reg[head_item.rn]);
        rd_zero_next = head_item.scan || (!rd_fwd_next && !tracked_vld_reg[head_item.rd]);
    end

    // Valid bits: a write marks its entry, a scan start clears them all.
    always_comb begin
        tracked_vld_next = tracked_vld_reg;
        if (b2_wr) begin
            tracked_vld_next[b2_item_reg.rd] = 1'b1;
        end
        if (pop && head_item.scan) begin
            tracked_vld_next = '0;
        end
    end

    // Stage occupancy.
    always_comb begin
        b2_valid_next  = pop ? 1'b1 : (b2_fire ? 1'b0 : b2_valid_reg);
        out_valid_next = b2_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracked_vld_reg <= '0;
            b2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            tracked_vld_reg <= tracked_vld_next;
            b2_valid_reg    <= b2_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Register file write port.
    always_ff @(posedge aclk) begin
        if (b2_wr) begin
            tracked_mem[b2_item_reg.rd] <= new_val;
        end
    end

    // Register file read ports, registered as the request enters execute.
    always_ff @(posedge aclk) begin
        if (pop) begin
            rn_raw_reg <= tracked_mem[head_item.rn];
            rd_raw_reg <= tracked_mem[head_item.rd];
        end
    end

    // Execute stage payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            b2_item_reg  <= head_item;
            fwd_data_reg <= new_val;
            rn_fwd_reg   <= rn_fwd_next;
            rd_fwd_reg   <= rd_fwd_next;
            rn_zero_reg  <= rn_zero_next;
            rd_zero_reg  <= rd_zero_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (b2_fire) begin
            out_kind_reg   <= out_kind_next;
            out_offset_reg <= b2_item_reg.offset;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = {out_kind_reg, out_kind_reg != cars_pkg::HIT_NONE};

    // A scan start leaves no entry marked valid behind it.
    a_scan_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_item.scan) |=> (tracked_vld_reg == '0))
        else $error("tracked entries still valid after a scan start");

    // Register 31 never reports a tracked hit.
    a_no_zero_reg_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_fire && b2_item_reg.rd == cars_pkg::ZERO_REG) |=>
        (out_kind_reg != cars_pkg::HIT_TRACKED))
        else $error("tracked hit reported on register 31");

    // ADD from register 31 is silent.
    a_clear_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_fire && b2_item_reg.cls == cars_pkg::CLS_CLEAR) |=>
        (out_kind_reg == cars_pkg::HIT_NONE))
        else $error("hit reported for an ADD from register 31");

    // A stalled execute request is neither dropped nor changed.
    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_valid_reg && !b2_fire) |=> (b2_valid_reg && $stable(b2_item_reg)))
        else $error("execute request lost while stalled");

endmodule

// ===== sv/code_address_reference_scanner.sv =====
// Top level of the code address reference scanner: target register, decode, queue and execute.
// The scanner takes one instruction word per cycle while the output side is ready and returns
// one result per word, in order, through the queue, the execute stage registers and the output
// register. The rate is set by the execute stage, which reads the 32-entry tracked register
// file once per word, does one 64-bit add and compare, and bypasses its own write to the next
// word. A scan start clears the file in the same cycle through per-entry valid bits, so there
// is no clearing pass after reset. A two-entry queue between decode and execute and an output
// register let the input keep flowing while a result waits. The target address may only be
// written while no word is in flight.
module code_address_reference_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instr_word [31:0], instr_offset [63:32]
    input  logic        s_tuser,   // scan_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hit_offset
    output logic [2:0]  m_tuser,   // hit [0], hit_kind [2:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data   // target_address
);

    logic [cars_pkg::VALUE_W-1:0] target_reg, target_next;
    logic                         queue_full;
    logic                         push;
    cars_pkg::item_t              push_item;
    logic                         pop;
    logic                         head_valid;
    cars_pkg::item_t              head_item;

    // Target address register, always ready for a request.
    assign cfg_ready = 1'b1;

    always_comb begin
        target_next = (cfg_valid && cfg_ready) ? cfg_data : target_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else begin
            target_reg <= target_next;
        end
    end

    cars_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    cars_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cars_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .target     (target_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
